### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, quiet while in reset.
`define ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, clocked on clk, quiet while in reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/u16u8_pkg.sv
// Shared types and constants of the UTF-16 to UTF-8 encoder.
package u16u8_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [31:0] HIGH_FIRST = 32'h0000_D800;
  localparam logic [31:0] HIGH_LAST  = 32'h0000_DBFF;
  localparam logic [31:0] LOW_FIRST  = 32'h0000_DC00;
  localparam logic [31:0] LOW_LAST   = 32'h0000_DFFF;
  localparam logic [31:0] CP_LIMIT   = 32'h0011_0000;
  localparam logic [20:0] SUPP_BASE  = 21'h01_0000;
  localparam logic [20:0] REPL_CHAR  = 21'h00_FFFD;
  localparam logic [20:0] LIM_1B     = 21'h00_0080;
  localparam logic [20:0] LIM_2B     = 21'h00_0800;
  localparam logic [20:0] LIM_3B     = 21'h01_0000;

  localparam logic [7:0] LEAD_2B   = 8'hC0;
  localparam logic [7:0] LEAD_3B   = 8'hE0;
  localparam logic [7:0] LEAD_4B   = 8'hF0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  // One encoded character (or terminator) as it waits for the byte serializer.
  typedef struct packed {
    logic [3:0][7:0] bytes;     // bytes[0] leaves first
    logic [1:0]      last_idx;  // index of the final byte
    logic            term;      // end-of-string zero byte
  } job_t;

endpackage

### rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds the byte groups.
module u16u8_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [31:0]      in_code_unit,
  input  logic             q_full,
  output logic             push,
  output u16u8_pkg::job_t  push_job
);
  import u16u8_pkg::*;

  logic        pending_r, pending_nxt;
  logic [9:0]  high_r, high_nxt;
  logic        fire, is_high, is_low, paired, over;
  logic [20:0] pair_cp, cp;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  assign is_high = (in_code_unit >= HIGH_FIRST) && (in_code_unit <= HIGH_LAST);
  assign is_low  = (in_code_unit >= LOW_FIRST) && (in_code_unit <= LOW_LAST);
  assign paired  = pending_r && is_low;
  assign pair_cp = {1'b0, high_r, in_code_unit[9:0]} + SUPP_BASE;
  // a joined pair never exceeds U+10FFFF
  assign over    = !paired && (in_code_unit >= CP_LIMIT);

  always_comb begin
    if (paired) begin
      cp = pair_cp;
    end else if (over) begin
      cp = REPL_CHAR;
    end else begin
      cp = in_code_unit[20:0];
    end
  end

  always_comb begin
    push_job = '0;
    if (in_kind) begin
      push_job.term     = 1'b1;
      push_job.last_idx = 2'd0;
    end else if (cp < LIM_1B) begin
      push_job.bytes[0] = {1'b0, cp[6:0]};
      push_job.last_idx = 2'd0;
    end else if (cp < LIM_2B) begin
      push_job.bytes[0] = LEAD_2B | {3'b0, cp[10:6]};
      push_job.bytes[1] = CONT_MARK | {2'b0, cp[5:0]};
      push_job.last_idx = 2'd1;
    end else if (cp < LIM_3B) begin
      push_job.bytes[0] = LEAD_3B | {4'b0, cp[15:12]};
      push_job.bytes[1] = CONT_MARK | {2'b0, cp[11:6]};
      push_job.bytes[2] = CONT_MARK | {2'b0, cp[5:0]};
      push_job.last_idx = 2'd2;
    end else begin
      push_job.bytes[0] = LEAD_4B | {5'b0, cp[20:18]};
      push_job.bytes[1] = CONT_MARK | {2'b0, cp[17:12]};
      push_job.bytes[2] = CONT_MARK | {2'b0, cp[11:6]};
      push_job.bytes[3] = CONT_MARK | {2'b0, cp[5:0]};
      push_job.last_idx = 2'd3;
    end
  end

  // a high surrogate is only held, it yields no bytes
  assign push = fire && (in_kind || !is_high);

  always_comb begin
    pending_nxt = pending_r;
    high_nxt    = high_r;
    if (fire) begin
      if (!in_kind && is_high) begin
        pending_nxt = 1'b1;
        high_nxt    = in_code_unit[9:0];
      end else begin
        pending_nxt = 1'b0;
        high_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      high_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      high_r    <= high_nxt;
    end
  end

endmodule

### rtl/u16u8_queue.sv
// Small job queue between the front end and the byte serializer.
module u16u8_queue #(
  parameter int unsigned DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  u16u8_pkg::job_t  push_job,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output u16u8_pkg::job_t  q_job
);
  import u16u8_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_job   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

### rtl/u16u8_back.sv
// Byte serializer: sends one byte of the current job per transaction.
module u16u8_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  u16u8_pkg::job_t  q_job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run,
  output logic             out_is_terminator
);
  import u16u8_pkg::*;

  job_t       job_r, job_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       at_last, done;

  assign at_last = (idx_r == job_r.last_idx);
  assign done    = busy_r && out_ready && at_last;
  // next job loads as the last byte of the current one goes out
  assign pop     = q_valid && (!busy_r || done);

  assign out_valid         = busy_r;
  assign out_byte          = job_r.bytes[idx_r];
  assign out_last_of_run   = at_last;
  assign out_is_terminator = job_r.term;

  always_comb begin
    job_nxt  = job_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      job_nxt  = q_job;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && out_ready) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

endmodule

### rtl/utf16_to_utf8_encoder.sv
// UTF-16 to UTF-8 encoder. Each accepted code unit yields 1 to 4 UTF-8 bytes, lead byte
// first; a held high surrogate yields none, and an end-of-string item yields one zero byte
// flagged as terminator. The output serializer moves one byte per cycle while out_ready is
// high, and a high surrogate never occupies it. A QUEUE_DEPTH-entry job queue between the
// front end and the serializer lets input be taken while bytes drain; an accepted item is
// written into the queue and then loaded into the serializer's job register, from which
// its first byte goes out. QUEUE_DEPTH must be 2 or more.
module utf16_to_utf8_encoder #(
  parameter int unsigned QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [31:0] in_code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run,
  output logic        out_is_terminator
);
  import u16u8_pkg::*;

  logic push, q_full, pop, q_valid;
  job_t push_job, q_job;

  u16u8_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_kind      (in_kind),
    .in_code_unit (in_code_unit),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  u16u8_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  u16u8_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_job             (q_job),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_is_terminator (out_is_terminator)
  );

endmodule

### rtl/u16u8_checker.sv
// Port-level checker for the encoder, bound to the top level.
`include "assert_macros.svh"

module u16u8_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       out_is_terminator
);

  // a stalled output transaction holds
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte))

  // terminator is a lone zero byte
  `ASSERT_NOW(a_term_zero, out_valid && out_is_terminator, out_byte == 8'h00 && out_last_of_run)

  // bytes of one character go out without gaps
  `ASSERT_NEXT(a_no_gap, out_valid && out_ready && !out_last_of_run, out_valid)

  // every byte after a non-final one is a continuation byte
  `ASSERT_NEXT(a_cont, out_valid && out_ready && !out_last_of_run, out_byte[7:6] == 2'b10)

endmodule

bind utf16_to_utf8_encoder u16u8_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_byte          (out_byte),
  .out_last_of_run   (out_last_of_run),
  .out_is_terminator (out_is_terminator)
);
